>>> sv/unit_normal_unpack_core_defines.svh
`ifndef UNIT_NORMAL_UNPACK_CORE_DEFINES_SVH
`define UNIT_NORMAL_UNPACK_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define UNU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define UNU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/unu_pkg.sv
package unu_pkg;

  localparam int COMPONENT_BITS_DEF = 14;
  localparam int QUEUE_DEPTH_DEF    = 4;
  localparam int PACKED_W           = 31;
  localparam int PAD_W              = 33;
  localparam int OUT_W              = 15;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // two's complement negate on request, wraps to the output width
  function automatic logic [OUT_W-1:0] apply_sign(input logic [OUT_W-1:0] mag,
                                                  input logic neg);
    apply_sign = neg ? (~mag + 1'b1) : mag;
  endfunction

endpackage

>>> sv/unit_normal_unpack_core.sv
// unit normal decode: packed x/z magnitudes and three signs in, signed x, y, z out
// input channel: in_valid / in_ready with in_packed_normal, one transaction per normal
// output channel: out_valid / out_ready with out_x_component, out_y_component and
//   out_z_component, signed, in units of 1/(2^COMPONENT_BITS - 1)
// y magnitude is the floor square root of the remaining length, zero when none is left
// throughput: one transaction per cycle on each side in steady state while out_ready stays high
// path from input to output transaction: two front stages (squares, then sum), one
//   queue slot, one square root stage per root bit, then the output register
// the front and the square root pipeline are split by a QUEUE_DEPTH entry queue; the
//   front stalls only when the queue is full, so in_ready never depends on out_ready
// when the receiver holds out_ready low with out_valid high, the output and the whole
//   root pipeline hold, the queue fills, and then in_ready drops
// reset clears all valid state and the queue; no output transaction is pending after it
`include "unit_normal_unpack_core_defines.svh"

module unit_normal_unpack_core
  import unu_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PACKED_W-1:0]     in_packed_normal,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_x_component,
  output logic signed [OUT_W-1:0] out_y_component,
  output logic signed [OUT_W-1:0] out_z_component
);

  localparam int ENTRY_W = 2 * OUT_W + 1 + 2 * COMPONENT_BITS;

  q_status_t          q_stat;
  logic               q_push;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_push_data;
  logic [ENTRY_W-1:0] q_pop_data;

  unu_front #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_packed_normal(in_packed_normal),
    .q_stat          (q_stat),
    .push            (q_push),
    .push_data       (q_push_data)
  );

  unu_queue #(
    .DATA_W(ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .q_stat   (q_stat)
  );

  unu_back #(
    .COMPONENT_BITS(COMPONENT_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .pop            (q_pop),
    .pop_data       (q_pop_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x_component(out_x_component),
    .out_y_component(out_y_component),
    .out_z_component(out_z_component)
  );

  `UNU_ASSERT_IMPL(a_queue_full_not_empty, q_stat.full, !q_stat.empty, "queue full and empty")
  `UNU_ASSERT_NEXT(a_full_stall_holds, q_stat.full && out_valid && !out_ready, !in_ready, "input taken while queue full and output stalled")
  `UNU_ASSERT_NEXT(a_empty_no_push_stays, q_stat.empty && !q_push, q_stat.empty, "queue left empty without a push")

endmodule

>>> sv/unu_queue.sv
module unu_queue
  import unu_pkg::*;
#(
  parameter int DATA_W = 61,
  parameter int DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output q_status_t         q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/unu_front.sv
module unu_front
  import unu_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [PACKED_W-1:0]                    in_packed_normal,
  input  q_status_t                              q_stat,
  output logic                                   push,
  output logic [2*OUT_W+2*COMPONENT_BITS:0]      push_data
);

  localparam int B     = COMPONENT_BITS;
  localparam int RAD_W = 2 * B;
  localparam int M     = (1 << B) - 1;
  localparam logic [RAD_W-1:0] FULL = RAD_W'(M * M);

  logic [PAD_W-1:0] word;
  logic [B-1:0]     xm, zm;
  logic             xs, zs, ys;
  logic             front_en;

  logic             va_r;
  logic [RAD_W-1:0] xsq_r, zsq_r;
  logic [OUT_W-1:0] xc_a_r, zc_a_r;
  logic             ys_a_r;

  logic             vb_r;
  logic [RAD_W:0]   used_r;
  logic [OUT_W-1:0] xc_b_r, zc_b_r;
  logic             ys_b_r;

  logic [RAD_W:0]   diff;
  logic             positive;
  logic [RAD_W-1:0] rad;

  assign word = PAD_W'(in_packed_normal);
  assign xm   = word[B-1:0];
  assign xs   = word[B];
  assign zm   = word[2*B:B+1];
  assign zs   = word[2*B+1];
  assign ys   = word[2*B+2];

  assign front_en = !q_stat.full;
  assign in_ready = front_en;

  // squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (front_en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      xsq_r  <= RAD_W'(xm) * RAD_W'(xm);
      zsq_r  <= RAD_W'(zm) * RAD_W'(zm);
      xc_a_r <= apply_sign(OUT_W'(xm), xs);
      zc_a_r <= apply_sign(OUT_W'(zm), zs);
      ys_a_r <= ys;
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (front_en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      used_r <= {1'b0, xsq_r} + {1'b0, zsq_r};
      xc_b_r <= xc_a_r;
      zc_b_r <= zc_a_r;
      ys_b_r <= ys_a_r;
    end
  end

  // radicand, zero when the remainder is not positive
  assign diff      = {1'b0, FULL} - used_r;
  assign positive  = used_r < {1'b0, FULL};
  assign rad       = positive ? diff[RAD_W-1:0] : '0;

  assign push      = front_en && vb_r;
  assign push_data = {xc_b_r, zc_b_r, ys_b_r, rad};

endmodule

>>> sv/unu_back.sv
module unu_back
  import unu_pkg::*;
#(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  q_status_t                         q_stat,
  output logic                              pop,
  input  logic [2*OUT_W+2*COMPONENT_BITS:0] pop_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [OUT_W-1:0]           out_x_component,
  output logic signed [OUT_W-1:0]           out_y_component,
  output logic signed [OUT_W-1:0]           out_z_component
);

  localparam int B     = COMPONENT_BITS;
  localparam int RAD_W = 2 * B;
  localparam int TRW   = RAD_W + 1;

  logic             back_en;
  logic [OUT_W-1:0] q_xc, q_zc;
  logic             q_ys;
  logic [RAD_W-1:0] q_rad;

  logic             sv_r   [B];
  logic [RAD_W-1:0] rem_r  [B];
  logic [B-1:0]     root_r [B];
  logic [OUT_W-1:0] sx_r   [B];
  logic [OUT_W-1:0] sz_r   [B];
  logic             sys_r  [B];

  logic             out_valid_r;
  logic [OUT_W-1:0] out_x_r, out_y_r, out_z_r;

  assign back_en = !out_valid_r || out_ready;
  assign pop     = back_en && !q_stat.empty;
  assign {q_xc, q_zc, q_ys, q_rad} = pop_data;

  // one root bit per stage, most significant first
  for (genvar s = 0; s < B; s++) begin : g_stage
    localparam int BIT = B - 1 - s;
    logic             v_in;
    logic [RAD_W-1:0] rem_in;
    logic [B-1:0]     root_in;
    logic [OUT_W-1:0] xc_in, zc_in;
    logic             ys_in;
    logic [TRW-1:0]   trial;
    logic             take;

    if (s == 0) begin : g_first
      assign v_in    = pop;
      assign rem_in  = q_rad;
      assign root_in = '0;
      assign xc_in   = q_xc;
      assign zc_in   = q_zc;
      assign ys_in   = q_ys;
    end else begin : g_next
      assign v_in    = sv_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign xc_in   = sx_r[s-1];
      assign zc_in   = sz_r[s-1];
      assign ys_in   = sys_r[s-1];
    end

    assign trial = (TRW'(root_in) << (BIT + 1)) | (TRW'(1) << (2 * BIT));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[s] <= 1'b0;
      end else if (back_en) begin
        sv_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (back_en) begin
        rem_r[s]  <= take ? rem_in - trial[RAD_W-1:0] : rem_in;
        root_r[s] <= take ? (root_in | (B'(1) << BIT)) : root_in;
        sx_r[s]   <= xc_in;
        sz_r[s]   <= zc_in;
        sys_r[s]  <= ys_in;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (back_en) begin
      out_valid_r <= sv_r[B-1];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      out_x_r <= sx_r[B-1];
      out_y_r <= apply_sign(OUT_W'(root_r[B-1]), sys_r[B-1]);
      out_z_r <= sz_r[B-1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_component = $signed(out_x_r);
  assign out_y_component = $signed(out_y_r);
  assign out_z_component = $signed(out_z_r);

endmodule

>>> tb/unit_normal_unpack_checker.sv
`timescale 1ns / 100ps

module unit_normal_unpack_checker
  import unu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [PACKED_W-1:0]     in_packed_normal,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [OUT_W-1:0] out_x_component,
  input  logic signed [OUT_W-1:0] out_y_component,
  input  logic signed [OUT_W-1:0] out_z_component,
  output int                      mismatch_count,
  output int                      pending_normals
);

  localparam int B = COMPONENT_BITS_DEF;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } normal_t;

  normal_t expected_normals[$];

  function automatic logic [OUT_W-1:0] with_sign(input longint unsigned mag, input logic neg);
    longint unsigned v;
    v = neg ? (64'd0 - mag) : mag;
    return v[OUT_W-1:0];
  endfunction

  // y magnitude is the floor square root of what x and z leave of the unit length
  function automatic normal_t decode_normal(input logic [PACKED_W-1:0] w);
    longint unsigned word, mask, xm, zm, full, used, rem, root, trial;
    logic xs, zs, ys;
    normal_t r;
    word = w;
    mask = (64'd1 << B) - 1;
    xm   = word & mask;
    xs   = word[B];
    zm   = (word >> (B + 1)) & mask;
    zs   = word[2*B+1];
    ys   = word[2*B+2];
    full = mask * mask;
    used = xm * xm + zm * zm;
    root = 0;
    if (used < full) begin
      rem = full - used;
      for (int b = B; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= rem) root = trial;
      end
    end
    r.x = with_sign(xm, xs);
    r.y = with_sign(root, ys);
    r.z = with_sign(zm, zs);
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    normal_t want;
    if (!rst_n) begin
      expected_normals.delete();
      mismatch_count = 0;
    end else begin
      // pop before push: a result never belongs to a same-cycle transaction
      if (out_valid && out_ready) begin
        if (expected_normals.size() == 0) begin
          $display("%0t unexpected result x %0d y %0d z %0d", $time,
                   out_x_component, out_y_component, out_z_component);
          mismatch_count++;
        end else begin
          want = expected_normals.pop_front();
          if (out_x_component !== want.x) begin
            $display("%0t x_component expected %0d got %0d", $time, want.x, out_x_component);
            mismatch_count++;
          end
          if (out_y_component !== want.y) begin
            $display("%0t y_component expected %0d got %0d", $time, want.y, out_y_component);
            mismatch_count++;
          end
          if (out_z_component !== want.z) begin
            $display("%0t z_component expected %0d got %0d", $time, want.z, out_z_component);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_normals.push_back(decode_normal(in_packed_normal));
    end
    pending_normals = expected_normals.size();
  end

endmodule

>>> tb/unit_normal_unpack_core_tb.sv
`timescale 1ns / 100ps

module unit_normal_unpack_core_tb;
  import unu_pkg::*;

  localparam int B = COMPONENT_BITS_DEF;
  localparam int M = (1 << B) - 1;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [PACKED_W-1:0]     in_packed_normal = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_x_component;
  logic signed [OUT_W-1:0] out_y_component;
  logic signed [OUT_W-1:0] out_z_component;

  int mismatch_count;
  int pending_normals;
  bit send_gaps  = 1'b1;
  bit recv_stall = 1'b1;

  unit_normal_unpack_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_packed_normal (in_packed_normal),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_x_component  (out_x_component),
    .out_y_component  (out_y_component),
    .out_z_component  (out_z_component)
  );

  unit_normal_unpack_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_packed_normal (in_packed_normal),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_x_component  (out_x_component),
    .out_y_component  (out_y_component),
    .out_z_component  (out_z_component),
    .mismatch_count   (mismatch_count),
    .pending_normals  (pending_normals)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(negedge clk) begin
    out_ready <= recv_stall ? ($urandom_range(0, 99) >= 23) : 1'b1;
  end

  function automatic logic [PACKED_W-1:0] pack_normal(input int xm, input bit xs, input int zm,
                                                      input bit zs, input bit ys);
    longint unsigned w;
    w = longint'(xm & M) | (longint'(xs) << B) | (longint'(zm & M) << (B + 1))
        | (longint'(zs) << (2*B + 1)) | (longint'(ys) << (2*B + 2));
    return w[PACKED_W-1:0];
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_normal(input logic [PACKED_W-1:0] w);
    while (send_gaps && $urandom_range(0, 99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_packed_normal = w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (pending_normals != 0) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic int pick_edge_mag();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return M - 1;
      default: return M;
    endcase
  endfunction

  initial begin
    int xm, zm, kind;
    logic [PACKED_W-1:0] w;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero, extremes, negative zero, remainder at or past the unit length
    send_normal(pack_normal(0, 0, 0, 0, 0));
    send_normal(pack_normal(0, 0, 0, 0, 1));
    send_normal(pack_normal(0, 1, 0, 1, 0));
    send_normal(pack_normal(0, 1, 0, 1, 1));
    send_normal({PACKED_W{1'b1}});
    send_normal(pack_normal(M, 0, 0, 0, 0));
    send_normal(pack_normal(M, 1, 0, 0, 1));
    send_normal(pack_normal(0, 0, M, 1, 1));
    send_normal(pack_normal(0, 1, M, 0, 0));
    send_normal(pack_normal(M, 0, M, 0, 0));
    send_normal(pack_normal(1, 0, 1, 1, 0));
    send_normal(pack_normal(M, 1, 1, 0, 1));
    send_normal(pack_normal(M - 1, 0, 0, 0, 1));
    send_normal(pack_normal(11585, 0, 11585, 0, 1));
    send_normal(pack_normal(11584, 1, 11584, 1, 0));
    send_normal(pack_normal(8191, 0, 8191, 1, 1));
    send_normal(pack_normal(1 << (B - 1), 1, 1 << (B - 1), 0, 0));
    send_normal(pack_normal(M / 2, 0, M / 3, 1, 0));
    drain_results();

    for (int i = 0; i < 950; i++) begin
      send_gaps  = !(i >= 300 && i < 450);
      recv_stall = !(i >= 250 && i < 400);
      if (i == 500) drain_results();
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        w = PACKED_W'($urandom());
      end else if (kind < 85) begin
        // close to the unit sphere, where the remainder crosses zero
        xm = $urandom_range(0, M);
        zm = $rtoi($sqrt(real'(M * M - xm * xm))) + $urandom_range(0, 4) - 2;
        if (zm < 0) zm = 0;
        if (zm > M) zm = M;
        if ($urandom_range(0, 1)) w = pack_normal(xm, $urandom_range(0, 1), zm,
                                                   $urandom_range(0, 1), $urandom_range(0, 1));
        else w = pack_normal(zm, $urandom_range(0, 1), xm,
                             $urandom_range(0, 1), $urandom_range(0, 1));
      end else begin
        w = pack_normal(pick_edge_mag(), $urandom_range(0, 1), pick_edge_mag(),
                        $urandom_range(0, 1), $urandom_range(0, 1));
      end
      send_normal(w);
    end

    in_valid = 1'b0;
    drain_results();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
